// File: rtl/paged_linear_allocator_assert.svh
// Assertion macros for the paged linear allocator checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef PAGED_LINEAR_ALLOCATOR_ASSERT_SVH
`define PAGED_LINEAR_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PAL_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("paged_linear_allocator: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PAL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("paged_linear_allocator: assertion failed");

`endif

// File: rtl/pal_pkg.sv
// Shared types and constants of the paged linear allocator.
// Depends on nothing; imported by every module of the block.
package pal_pkg;

   localparam int SIZE_W     = 25;
   localparam int ALIGN_W    = 5;
   localparam int FENCE_W    = 64;
   localparam int STATUS_W   = 2;
   localparam int PAGE_OUT_W = 6;
   localparam int ALU_W      = 64;
   localparam int AMASK_W    = 32;
   localparam int OFF_W      = 34;

   localparam logic [SIZE_W-1:0] PAGE_SIZE_RESET = 25'd65536;

   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_DISCARD = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERSIZE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAGE  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SIZE,
      ST_OFF,
      ST_FIT,
      ST_RWAIT,
      ST_RCHK,
      ST_FWAIT,
      ST_TAKE,
      ST_DWAIT,
      ST_DISC,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      ALU_PASS,
      ALU_ADD,
      ALU_ALIGN
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic [ALU_W-1:0] limit;
   } alu_req_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

endpackage

// File: rtl/paged_linear_allocator.sv
// Channel   Handshake            Beat contents
// csr       csr_valid/ready      page_size write data
// req       req_valid/stall      action, size, alignment, fence, completed fence
// rsp       rsp_valid/stall      status, page index, offset, aligned size, new page
// A fitting allocation passes ST_SIZE, ST_OFF and ST_FIT to ST_DONE; a page request
// loops ST_RWAIT/ST_RCHK moving retired pages to the free queue, then ST_FWAIT, ST_TAKE.
// A discard loops ST_DWAIT/ST_DISC until no page is pending; oversize exits at ST_SIZE.
// Reset is synchronous and needs no clearing pass; a stalled result beat holds its fields.
// Top level of the paged linear allocator; depends on pal_pkg, pal_alu and pal_fifo.
module paged_linear_allocator
   import pal_pkg::*;
#(
   parameter int MAX_PAGES = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SIZE_W-1:0]     csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [SIZE_W-1:0]     req_size_bytes,
   input  logic [ALIGN_W-1:0]    req_align_log2,
   input  logic [FENCE_W-1:0]    req_fence_value,
   input  logic [FENCE_W-1:0]    req_completed_fence,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [PAGE_OUT_W-1:0] rsp_page_index,
   output logic [SIZE_W-1:0]     rsp_offset,
   output logic [SIZE_W-1:0]     rsp_aligned_size,
   output logic                  rsp_new_page
);

   localparam int PAGE_W = $clog2(MAX_PAGES);
   localparam int CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int RET_W  = FENCE_W + PAGE_W;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]     page_size_ff, page_size_in;
   logic                  have_page_ff, have_page_in;
   logic [PAGE_W-1:0]     cur_page_ff, cur_page_in;
   logic [SIZE_W-1:0]     cur_off_ff, cur_off_in;
   logic [CNT_W-1:0]      created_ff, created_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [AMASK_W-1:0]    amask_ff, amask_in;
   logic [FENCE_W-1:0]    fence_ff, fence_in;
   logic [FENCE_W-1:0]    done_fence_ff, done_fence_in;
   logic [SIZE_W-1:0]     aligned_ff, aligned_in;
   logic [OFF_W-1:0]      off_ff, off_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [PAGE_OUT_W-1:0] res_page_ff, res_page_in;
   logic [SIZE_W-1:0]     res_off_ff, res_off_in;
   logic [SIZE_W-1:0]     res_size_ff, res_size_in;
   logic                  res_new_ff, res_new_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [PAGE_OUT_W-1:0] rsp_page_ff, rsp_page_in;
   logic [SIZE_W-1:0]     rsp_off_ff, rsp_off_in;
   logic [SIZE_W-1:0]     rsp_size_ff, rsp_size_in;
   logic                  rsp_new_ff, rsp_new_in;

   alu_req_type      alu_req;
   logic [ALU_W-1:0] alu_result;
   logic             alu_gt;

   fifo_ctl_type      pend_ctl, free_ctl, ret_ctl;
   logic [PAGE_W-1:0] pend_head, free_head, free_push_data;
   logic [RET_W-1:0]  ret_head, ret_push_data;
   logic [CNT_W-1:0]  pend_count, free_count, ret_count;
   logic              accept;
   logic              rsp_load;
   logic              fits;
   logic              can_drain;

   pal_alu u_alu (
      .alu_req    (alu_req),
      .alu_result (alu_result),
      .alu_gt     (alu_gt)
   );

   pal_fifo #(.DEPTH(MAX_PAGES), .WIDTH(PAGE_W)) u_pend_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pend_ctl),
      .push_data (cur_page_ff),
      .head_data (pend_head),
      .count     (pend_count)
   );

   pal_fifo #(.DEPTH(MAX_PAGES), .WIDTH(PAGE_W)) u_free_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (free_ctl),
      .push_data (free_push_data),
      .head_data (free_head),
      .count     (free_count)
   );

   pal_fifo #(.DEPTH(MAX_PAGES), .WIDTH(RET_W)) u_ret_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ret_ctl),
      .push_data (ret_push_data),
      .head_data (ret_head),
      .count     (ret_count)
   );

   always_comb begin
      accept    = (state_ff == ST_IDLE) && req_valid;
      rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
      fits      = have_page_ff && !alu_gt;
      can_drain = (ret_count != '0) && !alu_gt;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_action == ACT_DISCARD) ? ST_DWAIT : ST_SIZE;
            end
         end
         ST_SIZE:  state_in = alu_gt ? ST_DONE : ST_OFF;
         ST_OFF:   state_in = ST_FIT;
         ST_FIT:   state_in = fits ? ST_DONE : ST_RWAIT;
         ST_RWAIT: state_in = ST_RCHK;
         ST_RCHK:  state_in = can_drain ? ST_RWAIT : ST_FWAIT;
         ST_FWAIT: state_in = ST_TAKE;
         ST_TAKE:  state_in = ST_DONE;
         ST_DWAIT: state_in = ST_DISC;
         ST_DISC:  state_in = (pend_count != '0) ? ST_DWAIT : ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      csr_ready      = (state_ff == ST_IDLE);
      req_stall      = (state_ff != ST_IDLE);
      page_size_in   = page_size_ff;
      have_page_in   = have_page_ff;
      cur_page_in    = cur_page_ff;
      cur_off_in     = cur_off_ff;
      created_in     = created_ff;
      size_in        = size_ff;
      amask_in       = amask_ff;
      fence_in       = fence_ff;
      done_fence_in  = done_fence_ff;
      aligned_in     = aligned_ff;
      off_in         = off_ff;
      res_status_in  = res_status_ff;
      res_page_in    = res_page_ff;
      res_off_in     = res_off_ff;
      res_size_in    = res_size_ff;
      res_new_in     = res_new_ff;
      alu_req.op     = ALU_PASS;
      alu_req.a      = '0;
      alu_req.b      = '0;
      alu_req.limit  = ALU_W'(page_size_ff);
      pend_ctl       = '0;
      free_ctl       = '0;
      ret_ctl        = '0;
      free_push_data = ret_head[PAGE_W-1:0];
      ret_push_data  = {fence_ff, (pend_count != '0) ? pend_head : cur_page_ff};

      if (csr_valid && csr_ready) begin
         page_size_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               size_in       = req_size_bytes;
               amask_in      = (AMASK_W'(1) << req_align_log2) - AMASK_W'(1);
               fence_in      = req_fence_value;
               done_fence_in = req_completed_fence;
               res_status_in = STATUS_OK;
               res_page_in   = '0;
               res_off_in    = '0;
               res_size_in   = '0;
               res_new_in    = 1'b0;
            end
         end
         ST_SIZE: begin
            alu_req.op = ALU_ALIGN;
            alu_req.a  = ALU_W'(size_ff);
            alu_req.b  = ALU_W'(amask_ff);
            aligned_in = alu_result[SIZE_W-1:0];
            if (alu_gt) begin
               res_status_in = STATUS_OVERSIZE;
            end
         end
         ST_OFF: begin
            alu_req.op = ALU_ALIGN;
            alu_req.a  = ALU_W'(cur_off_ff);
            alu_req.b  = ALU_W'(amask_ff);
            off_in     = alu_result[OFF_W-1:0];
         end
         ST_FIT: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = ALU_W'(off_ff);
            alu_req.b  = ALU_W'(aligned_ff);
            if (fits) begin
               res_page_in = PAGE_OUT_W'(cur_page_ff);
               res_off_in  = off_ff[SIZE_W-1:0];
               res_size_in = aligned_ff;
               cur_off_in  = alu_result[SIZE_W-1:0];
            end else if (have_page_ff) begin
               pend_ctl.push = 1'b1;
               have_page_in  = 1'b0;
            end
         end
         ST_RCHK: begin
            alu_req.op    = ALU_PASS;
            alu_req.a     = ret_head[RET_W-1:PAGE_W];
            alu_req.limit = done_fence_ff;
            if (can_drain) begin
               ret_ctl.pop   = 1'b1;
               free_ctl.push = 1'b1;
            end
         end
         ST_TAKE: begin
            if (free_count != '0) begin
               free_ctl.pop = 1'b1;
               cur_page_in  = free_head;
            end else begin
               cur_page_in = created_ff[PAGE_W-1:0];
            end
            if ((free_count != '0) || (created_ff != CNT_W'(MAX_PAGES))) begin
               if (free_count == '0) begin
                  created_in = created_ff + 1'b1;
                  res_new_in = 1'b1;
               end
               have_page_in = 1'b1;
               cur_off_in   = aligned_ff;
               res_page_in  = PAGE_OUT_W'(cur_page_in);
               res_off_in   = '0;
               res_size_in  = aligned_ff;
            end else begin
               cur_page_in   = cur_page_ff;
               cur_off_in    = '0;
               res_status_in = STATUS_NO_PAGE;
            end
         end
         ST_DISC: begin
            if (pend_count != '0) begin
               pend_ctl.pop = 1'b1;
               ret_ctl.push = 1'b1;
            end else begin
               ret_ctl.push = have_page_ff;
               have_page_in = 1'b0;
               cur_off_in   = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_new_in    = rsp_new_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_page_in   = res_page_ff;
         rsp_off_in    = res_off_ff;
         rsp_size_in   = res_size_ff;
         rsp_new_in    = res_new_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         page_size_ff <= PAGE_SIZE_RESET;
         have_page_ff <= 1'b0;
         cur_page_ff  <= '0;
         cur_off_ff   <= '0;
         created_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         page_size_ff <= page_size_in;
         have_page_ff <= have_page_in;
         cur_page_ff  <= cur_page_in;
         cur_off_ff   <= cur_off_in;
         created_ff   <= created_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      amask_ff      <= amask_in;
      fence_ff      <= fence_in;
      done_fence_ff <= done_fence_in;
      aligned_ff    <= aligned_in;
      off_ff        <= off_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      res_off_ff    <= res_off_in;
      res_size_ff   <= res_size_in;
      res_new_ff    <= res_new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_new_ff    <= rsp_new_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_index   = rsp_page_ff;
   assign rsp_offset       = rsp_off_ff;
   assign rsp_aligned_size = rsp_size_ff;
   assign rsp_new_page     = rsp_new_ff;

endmodule

// File: rtl/pal_alu.sv
// Shared add, align and compare unit of the paged linear allocator.
// Depends on pal_pkg for the request type and operation codes.
module pal_alu
   import pal_pkg::*;
(
   input  alu_req_type      alu_req,
   output logic [ALU_W-1:0] alu_result,
   output logic             alu_gt
);

   logic [ALU_W-1:0] sum;

   always_comb begin
      sum = alu_req.a + alu_req.b;
      case (alu_req.op)
         ALU_PASS:  alu_result = alu_req.a;
         ALU_ADD:   alu_result = sum;
         ALU_ALIGN: alu_result = sum & ~alu_req.b;
         default:   alu_result = alu_req.a;
      endcase
      alu_gt = (alu_result > alu_req.limit);
   end

endmodule

// File: rtl/pal_fifo.sv
// Ring-buffer queue with one write port, one read port and a registered head read.
// Depends on pal_pkg for the push and pop control type.
module pal_fifo
   import pal_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int WIDTH = 6
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  fifo_ctl_type                 ctl,
   input  logic [WIDTH-1:0]             push_data,
   output logic [WIDTH-1:0]             head_data,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] head_data_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      do_push  = ctl.push && (count_ff != CNT_W'(DEPTH));
      do_pop   = ctl.pop && (count_ff != '0);
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      if (do_push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail_ff] <= push_data;
      end
      head_data_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign head_data = head_data_ff;
   assign count     = count_ff;

endmodule

// File: rtl/pal_checker.sv
// Port-level checker for the paged linear allocator, bound to the top level.
// Depends on pal_pkg and the assertion macros in paged_linear_allocator_assert.svh.
`include "paged_linear_allocator_assert.svh"

module pal_checker
   import pal_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [PAGE_OUT_W-1:0] rsp_page_index,
   input logic [SIZE_W-1:0]     rsp_offset,
   input logic [SIZE_W-1:0]     rsp_aligned_size,
   input logic                  rsp_new_page
);

   // The block works on one beat at a time.
   `PAL_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   `PAL_ASSERT_IMP(a_fail_fields_zero, clock, reset, rsp_valid && (rsp_status != STATUS_OK), (rsp_page_index == '0) && (rsp_offset == '0) && (rsp_aligned_size == '0) && !rsp_new_page)

   // A freshly created page always starts the allocation at offset zero.
   `PAL_ASSERT_IMP(a_new_page_at_zero, clock, reset, rsp_valid && rsp_new_page, (rsp_status == STATUS_OK) && (rsp_offset == '0))

   `PAL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_page_index) && $stable(rsp_offset) && $stable(rsp_aligned_size) && $stable(rsp_new_page))

endmodule

bind paged_linear_allocator pal_checker u_pal_checker (.*);

// File: verif/paged_linear_allocator_checker.sv
`timescale 1ns / 100ps
// Checker for the paged linear allocator: watches the csr, req and rsp channels,
// predicts every result beat and compares it field by field. Depends on pal_pkg.
module paged_linear_allocator_checker
   import pal_pkg::*;
#(
   parameter int MAX_PAGES = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [SIZE_W-1:0]     csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_action,
   input  logic [SIZE_W-1:0]     req_size_bytes,
   input  logic [ALIGN_W-1:0]    req_align_log2,
   input  logic [FENCE_W-1:0]    req_fence_value,
   input  logic [FENCE_W-1:0]    req_completed_fence,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic [PAGE_OUT_W-1:0] rsp_page_index,
   input  logic [SIZE_W-1:0]     rsp_offset,
   input  logic [SIZE_W-1:0]     rsp_aligned_size,
   input  logic                  rsp_new_page,
   output int                    mismatches,
   output int                    grants_owed
);

   typedef struct {
      logic [STATUS_W-1:0]   status;
      logic [PAGE_OUT_W-1:0] page_index;
      logic [SIZE_W-1:0]     offset;
      logic [SIZE_W-1:0]     aligned_size;
      logic                  new_page;
   } grant_type;

   typedef struct {
      logic [FENCE_W-1:0] fence;
      int                 page;
   } retired_type;

   grant_type         grants_due[$];
   logic [SIZE_W-1:0] page_size;
   logic              holding;
   int                cur_page;
   logic [63:0]       cur_offset;
   int                pending_pages[$];
   int                free_pages[$];
   retired_type       retired_pages[$];
   int                pages_made;
   int                fault_count = 0;

   assign mismatches = fault_count;

   task automatic report_fault(input string msg);
      $display("%0t ns allocator checker: %s", $time, msg);
      fault_count++;
   endtask

   function automatic grant_type allocate_or_discard(
      input logic               action,
      input logic [SIZE_W-1:0]  size,
      input logic [ALIGN_W-1:0] alog,
      input logic [FENCE_W-1:0] fence,
      input logic [FENCE_W-1:0] completed
   );
      grant_type   g;
      retired_type r;
      logic [63:0] amask;
      logic [63:0] aligned;
      logic [63:0] off;
      g = '{default: '0};
      if (action == ACT_DISCARD) begin
         r.fence = fence;
         foreach (pending_pages[i]) begin
            r.page = pending_pages[i];
            if (retired_pages.size() < MAX_PAGES)
               retired_pages.insert(retired_pages.size(), r);
         end
         pending_pages.delete();
         if (holding && retired_pages.size() < MAX_PAGES) begin
            r.page = cur_page;
            retired_pages.insert(retired_pages.size(), r);
         end
         holding = 1'b0;
         cur_offset = '0;
         return g;
      end
      amask = (64'd1 << alog) - 64'd1;
      aligned = (64'(size) + amask) & ~amask;
      if (aligned > 64'(page_size)) begin
         g.status = STATUS_OVERSIZE;
         return g;
      end
      off = (cur_offset + amask) & ~amask;
      if (holding && off + aligned > 64'(page_size)) begin
         if (pending_pages.size() < MAX_PAGES)
            pending_pages.insert(pending_pages.size(), cur_page);
         holding = 1'b0;
      end
      if (!holding) begin
         while (retired_pages.size() > 0 && retired_pages[0].fence <= completed) begin
            r = retired_pages.pop_front();
            if (free_pages.size() < MAX_PAGES) free_pages.insert(free_pages.size(), r.page);
         end
         if (free_pages.size() > 0) begin
            cur_page = free_pages.pop_front();
         end else if (pages_made < MAX_PAGES) begin
            cur_page = pages_made;
            pages_made++;
            g.new_page = 1'b1;
         end else begin
            cur_offset = '0;
            g.status = STATUS_NO_PAGE;
            return g;
         end
         holding = 1'b1;
         off = '0;
      end
      g.status = STATUS_OK;
      g.page_index = PAGE_OUT_W'(cur_page);
      g.offset = off[SIZE_W-1:0];
      g.aligned_size = aligned[SIZE_W-1:0];
      cur_offset = (off + aligned) & 64'h1FF_FFFF;
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         page_size = PAGE_SIZE_RESET;
         holding = 1'b0;
         cur_page = 0;
         cur_offset = '0;
         pages_made = 0;
         pending_pages.delete();
         free_pages.delete();
         retired_pages.delete();
         grants_due.delete();
      end else begin
         if (csr_valid && csr_ready) page_size = csr_wdata;
         if (rsp_valid && !rsp_stall) begin
            if (grants_due.size() == 0) begin
               report_fault("result beat with no request outstanding");
            end else begin
               want = grants_due.pop_front();
               if (rsp_status !== want.status)
                  report_fault($sformatf("status: got %0d, want %0d", rsp_status, want.status));
               if (rsp_page_index !== want.page_index)
                  report_fault($sformatf("page_index: got %0d, want %0d",
                                         rsp_page_index, want.page_index));
               if (rsp_offset !== want.offset)
                  report_fault($sformatf("offset: got %0d, want %0d", rsp_offset, want.offset));
               if (rsp_aligned_size !== want.aligned_size)
                  report_fault($sformatf("aligned_size: got %0d, want %0d",
                                         rsp_aligned_size, want.aligned_size));
               if (rsp_new_page !== want.new_page)
                  report_fault($sformatf("new_page: got %0d, want %0d",
                                         rsp_new_page, want.new_page));
            end
         end
         if (req_valid && !req_stall)
            grants_due.insert(grants_due.size(),
                              allocate_or_discard(req_action, req_size_bytes, req_align_log2,
                                                  req_fence_value, req_completed_fence));
      end
      grants_owed = grants_due.size();
   end

endmodule

// File: verif/paged_linear_allocator_tb.sv
`timescale 1ns / 100ps
// Testbench top for the paged linear allocator: clock, reset, stimulus and verdict.
// Depends on pal_pkg, the allocator RTL and paged_linear_allocator_checker.
module paged_linear_allocator_tb;
   import pal_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int SEGMENTS       = 8;
   localparam int SEGMENT_ITEMS  = 250;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [SIZE_W-1:0]     csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_action;
   logic [SIZE_W-1:0]     req_size_bytes;
   logic [ALIGN_W-1:0]    req_align_log2;
   logic [FENCE_W-1:0]    req_fence_value;
   logic [FENCE_W-1:0]    req_completed_fence;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic [PAGE_OUT_W-1:0] rsp_page_index;
   logic [SIZE_W-1:0]     rsp_offset;
   logic [SIZE_W-1:0]     rsp_aligned_size;
   logic                  rsp_new_page;

   int                 mismatches;
   int                 grants_owed;
   int                 quiet_cycles = 0;
   int                 idle_pct = 0;
   int                 stall_pct = 0;
   logic [SIZE_W-1:0]  page_bytes;
   logic [FENCE_W-1:0] fence_seq;

   int unsigned segment_bytes [SEGMENTS] = '{256, 64, 4096, 1, 16777216, 96, 65536, 16};
   int          segment_discard_pct [SEGMENTS] = '{12, 2, 25, 6, 12, 2, 25, 6};
   int          segment_lag [SEGMENTS] = '{4, 16, 0, 2, 1, 8, 3, 0};

   paged_linear_allocator i_dut (.*);

   paged_linear_allocator_checker i_checker (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(negedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[paged_linear_allocator] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(
      input logic               action,
      input logic [SIZE_W-1:0]  size,
      input logic [ALIGN_W-1:0] alog,
      input logic [FENCE_W-1:0] fence,
      input logic [FENCE_W-1:0] completed
   );
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_action = action;
      req_size_bytes = size;
      req_align_log2 = alog;
      req_fence_value = fence;
      req_completed_fence = completed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (grants_owed != 0) @(negedge clock);
   endtask

   task automatic set_page_size(input logic [SIZE_W-1:0] bytes);
      wait_drained();
      csr_valid = 1'b1;
      csr_wdata = bytes;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      page_bytes = bytes;
   endtask

   task automatic send_random(input int discard_pct, input int lag_max);
      int                 pick;
      logic [SIZE_W-1:0]  size;
      logic [ALIGN_W-1:0] alog;
      logic [FENCE_W-1:0] fence;
      logic [FENCE_W-1:0] completed;
      pick = $urandom_range(99);
      size = SIZE_W'($urandom);
      alog = ALIGN_W'($urandom);
      fence = {$urandom, $urandom};
      completed = {$urandom, $urandom};
      if (pick < 3) begin
         send_item(1'($urandom_range(1)), size, alog, fence, completed);
      end else if (pick < 3 + discard_pct) begin
         fence_seq = fence_seq + 64'd1;
         send_item(ACT_DISCARD, size, alog, fence_seq, completed);
      end else begin
         if ($urandom_range(9) != 0) begin
            alog = ALIGN_W'($urandom_range(0, 6));
            size = page_bytes >> $urandom_range(1, 8);
            size = SIZE_W'($urandom_range(0, size));
         end
         if ($urandom_range(19) != 0)
            completed = fence_seq - 64'($urandom_range(0, lag_max));
         send_item(ACT_ALLOC, size, alog, fence, completed);
      end
   endtask

   initial begin
      int seg;
      int n;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_action = ACT_ALLOC;
      req_size_bytes = '0;
      req_align_log2 = '0;
      req_fence_value = '0;
      req_completed_fence = '0;
      page_bytes = PAGE_SIZE_RESET;
      fence_seq = 64'd1000;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      send_item(ACT_ALLOC, 25'd0, 5'd0, '0, '0);
      send_item(ACT_ALLOC, 25'd100, 5'd4, '0, '0);
      send_item(ACT_ALLOC, 25'd65536, 5'd0, '0, '0);
      send_item(ACT_ALLOC, 25'd65537, 5'd0, '0, '0);
      send_item(ACT_ALLOC, '1, 5'd31, '0, '0);
      send_item(ACT_ALLOC, 25'd1, 5'd16, '0, '0);
      send_item(ACT_ALLOC, 25'd0, 5'd31, '0, '0);
      send_item(ACT_DISCARD, 25'd0, 5'd0, '1, '0);
      send_item(ACT_DISCARD, '1, '1, '0, '1);
      send_item(ACT_ALLOC, 25'd8, 5'd3, '0, '0);
      send_item(ACT_DISCARD, 25'd0, 5'd0, 64'd5, '0);
      send_item(ACT_ALLOC, 25'd64, 5'd2, '0, 64'd4);
      send_item(ACT_ALLOC, 25'd65536, 5'd0, '0, '1);
      set_page_size(25'd0);
      send_item(ACT_ALLOC, 25'd0, 5'd0, '0, '0);
      send_item(ACT_ALLOC, 25'd1, 5'd0, '0, '0);
      send_item(ACT_ALLOC, 25'd0, 5'd5, '0, '0);
      set_page_size(25'd1);
      send_item(ACT_ALLOC, 25'd1, 5'd0, '0, '0);
      send_item(ACT_ALLOC, 25'd1, 5'd0, '0, '0);
      set_page_size(25'd16777216);
      send_item(ACT_ALLOC, 25'd16777216, 5'd0, '0, '0);
      send_item(ACT_ALLOC, '1, 5'd0, '0, '0);
      set_page_size('1);
      send_item(ACT_ALLOC, '1, 5'd0, '0, '0);
      send_item(ACT_DISCARD, 25'd0, 5'd0, fence_seq, '0);

      for (seg = 0; seg < SEGMENTS; seg++) begin
         set_page_size(SIZE_W'(segment_bytes[seg]));
         case (seg % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 80;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 80;
            end
            default: begin
               idle_pct = 10;
               stall_pct = 10;
            end
         endcase
         for (n = 0; n < SEGMENT_ITEMS; n++) begin
            if ($urandom_range(199) == 0) wait_drained();
            send_random(segment_discard_pct[seg], segment_lag[seg]);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("[paged_linear_allocator] OK");
      else
         $display("[paged_linear_allocator] ERROR");
      $finish;
   end

endmodule
